// ----- design/sded_pkg.sv -----
// ----------------------------------------------------------------------------
// sded_pkg: shared types and constants for the spell duration edit distance
// Field widths, function codes and defaults used by the core and its parts.
// ----------------------------------------------------------------------------
package sded_pkg;

  localparam int unsigned MaxLenDefault    = 64;
  localparam int unsigned NumStatesDefault = 16;

  localparam int unsigned StateW = 4;
  localparam int unsigned CostW  = 24;
  localparam int unsigned DurW   = 12;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CellW  = 32;
  localparam int unsigned WdurW  = WeightW + DurW;

  localparam logic [WeightW-1:0] WeightReset = 16'd256;
  localparam logic [CellW-1:0]   CellMax     = '1;

  typedef enum logic [1:0] {
    FUNC_SUB   = 2'd0,
    FUNC_INDEL = 2'd1,
    FUNC_A     = 2'd2,
    FUNC_B     = 2'd3
  } func_e;

  // Saturating clamp of a wide candidate to a DP cell.
  function automatic logic [CellW-1:0] clamp_cell(input logic [CellW+1:0] v);
    logic [CellW-1:0] r;
    r = (v[CellW+1:CellW] != 2'd0) ? CellMax : v[CellW-1:0];
    return r;
  endfunction

endpackage

// ----- design/sded_mem.sv -----
// ----------------------------------------------------------------------------
// sded_mem: generic synchronous RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module sded_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/spell_duration_edit_distance_core.sv -----
// ----------------------------------------------------------------------------
// spell_duration_edit_distance_core: duration-weighted spell edit distance
// Table loads, sequence A storage and a column sweep per sequence B element.
// ----------------------------------------------------------------------------
// Table writes and sequence A elements are taken while idle and can
// follow back to back. A sequence B element sweeps one DP column held in a RAM,
// one cell at a time: after a state for its own indel lookup, each of the
// a_length+1 cells passes in turn through row/A element read, cost lookup,
// duration multiply and add/compare/write back, then a closing state. A B
// element keeps the input blocked for its whole sweep; the first B element
// of a pair also builds the initial column before it. A B element beyond the
// maximum length is dropped without a sweep. The final B element's result is
// valid the cycle after the closing state and is held in an output register;
// once idle, the input is refused only while that result waits unaccepted.
// No reset sweep: all tables are undefined until written.
module spell_duration_edit_distance_core
  import sded_pkg::*;
#(
  parameter int unsigned MAX_LEN    = MaxLenDefault,
  parameter int unsigned NUM_STATES = NumStatesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [WeightW-1:0]  cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [StateW-1:0]   row_state_i,
  input  logic [StateW-1:0]   col_state_i,
  input  logic [CostW-1:0]    cost_value_i,
  input  logic [DurW-1:0]     duration_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CellW-1:0]    distance_o,
  output logic                saturated_o,
  output logic                too_long_o
);

  localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam int unsigned RowW  = $clog2(MAX_LEN + 1);
  localparam int unsigned SubDepth = NUM_STATES * NUM_STATES;
  localparam int unsigned SubAW = $clog2(SubDepth);
  localparam int unsigned IndAW = $clog2(NUM_STATES);
  localparam int unsigned SeqW  = StateW + DurW;

  typedef enum logic [2:0] {
    S_IDLE, S_JIND, S_RD, S_LOOK, S_MUL, S_CALC, S_DONE
  } state_e;

  state_e state_q;
  logic [WeightW-1:0] weight_q;
  logic [LenW-1:0] a_len_q, b_cnt_q;
  logic sat_q, long_q, a_closed_q;
  logic first_q;              // building initial column
  logic last_q;
  logic [StateW-1:0] js_q;
  logic [DurW-1:0]   jdur_q;
  logic [RowW-1:0]   i_q;     // current row
  logic [CellW-1:0]  diag_q, left_q;
  logic [CostW-1:0]  jind_q;
  logic              jvalid_q;
  logic out_valid_q;
  logic [CellW-1:0] dist_q;
  logic osat_q, olong_q;

  // memories
  logic sub_we, ind_we, seq_we, row_we;
  logic [SubAW-1:0] sub_waddr, sub_raddr;
  logic [IndAW-1:0] ind_waddr, ind_raddr;
  logic [CostW-1:0] sub_rdata, ind_rdata;
  logic [AW-1:0]    seq_addr_w, seq_raddr;
  logic [SeqW-1:0]  seq_rdata;
  logic [RowW-1:0]  row_waddr, row_raddr;
  logic [CellW-1:0] row_wdata, row_rdata;

  sded_mem #(.Depth(SubDepth), .Width(CostW)) u_sub (
    .clk_i, .we_i(sub_we), .waddr_i(sub_waddr), .wdata_i(cost_value_i),
    .raddr_i(sub_raddr), .rdata_o(sub_rdata));
  sded_mem #(.Depth(NUM_STATES), .Width(CostW)) u_ind (
    .clk_i, .we_i(ind_we), .waddr_i(ind_waddr), .wdata_i(cost_value_i),
    .raddr_i(ind_raddr), .rdata_o(ind_rdata));
  sded_mem #(.Depth(MAX_LEN), .Width(SeqW)) u_seq (
    .clk_i, .we_i(seq_we), .waddr_i(seq_addr_w),
    .wdata_i({row_state_i, duration_i}), .raddr_i(seq_raddr), .rdata_o(seq_rdata));
  sded_mem #(.Depth(MAX_LEN + 1), .Width(CellW)) u_row (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .raddr_i(row_raddr), .rdata_o(row_rdata));

  logic in_fire;
  logic rs_ok, cs_ok;
  assign in_ready_o  = (state_q == S_IDLE) && !(out_valid_q && !out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign rs_ok = ({4'd0, row_state_i} < 8'(NUM_STATES)) || (NUM_STATES > 15);
  assign cs_ok = ({4'd0, col_state_i} < 8'(NUM_STATES)) || (NUM_STATES > 15);

  logic a_new;      // A element restarts pair
  logic [LenW-1:0] a_len_eff;
  assign a_new = a_closed_q && (func_e'(func_i) == FUNC_A);
  assign a_len_eff = a_new ? '0 : a_len_q;

  assign sub_we    = in_fire && (func_e'(func_i) == FUNC_SUB) && rs_ok && cs_ok;
  assign sub_waddr = SubAW'(32'(row_state_i) * NUM_STATES + 32'(col_state_i));
  assign ind_we    = in_fire && (func_e'(func_i) == FUNC_INDEL) && rs_ok;
  assign ind_waddr = IndAW'(row_state_i);
  assign seq_we    = in_fire && (func_e'(func_i) == FUNC_A) &&
                     (32'(a_len_eff) < MAX_LEN);
  assign seq_addr_w = AW'(a_len_eff);

  // A element of the current row i (1-based), valid in S_LOOK
  logic [StateW-1:0] as_w;
  logic [DurW-1:0]   adur_w;
  assign as_w   = seq_rdata[SeqW-1:DurW];
  assign adur_w = seq_rdata[DurW-1:0];
  logic as_ok;
  assign as_ok = ({4'd0, as_w} < 8'(NUM_STATES)) || (NUM_STATES > 15);

  assign seq_raddr = AW'(i_q - RowW'(1));
  assign sub_raddr = SubAW'(32'(as_w) * NUM_STATES + 32'(js_q));
  assign ind_raddr = (state_q == S_IDLE) ? IndAW'(row_state_i) : IndAW'(as_w);
  assign row_raddr = i_q;

  // per-cell pipeline registers
  logic [StateW-1:0] as_q;
  logic [DurW-1:0]   adur_q;
  logic              as_ok_q;
  logic [CostW-1:0]  aind_q, subc_q;
  logic [WdurW-1:0]  da_q, dj_q;
  logic [CellW-1:0]  up_q;

  // cell compute
  logic [CostW-1:0] aind_use, subc_use;
  logic [CellW+1:0] insj_w;   // indel + wdur of B element
  logic [CellW+1:0] c_del, c_ins, c_sub, c_best;
  logic [WdurW-1:0] ddiff;
  logic             cell_ovf;
  assign aind_use = as_ok_q ? aind_q : CostW'(0);
  assign subc_use = (as_ok_q && jvalid_q) ? subc_q : CostW'(0);
  assign insj_w   = {10'd0, jind_q} + {6'd0, dj_q};

  always_comb begin
    ddiff = (da_q > dj_q) ? (da_q - dj_q) : (dj_q - da_q);
    c_del = {2'd0, left_q} + {10'd0, aind_use} + {6'd0, da_q};
    c_ins = {2'd0, up_q} + insj_w;
    if (as_q == js_q) begin
      c_sub = {2'd0, diag_q} + {6'd0, ddiff};
    end else begin
      c_sub = {2'd0, diag_q} + {10'd0, subc_use} + {6'd0, da_q} + {6'd0, dj_q};
    end
    // Row zero: 0 for the initial column, old row zero plus ins_j otherwise.
    if (i_q == '0) begin
      c_best = first_q ? '0 : c_ins;
    end else if (first_q) begin
      c_best = c_del;
    end else begin
      c_best = c_ins;
      if (c_del < c_best) c_best = c_del;
      if (c_sub < c_best) c_best = c_sub;
    end
  end

  logic [CellW-1:0] cell_w;
  assign cell_w    = clamp_cell(c_best);
  assign cell_ovf  = (c_best[CellW+1:CellW] != 2'd0);
  assign row_we    = (state_q == S_CALC);
  assign row_waddr = i_q;
  assign row_wdata = cell_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      weight_q <= WeightReset;
      a_len_q <= '0; b_cnt_q <= '0;
      sat_q <= 1'b0; long_q <= 1'b0; a_closed_q <= 1'b0;
      first_q <= 1'b0; last_q <= 1'b0;
      js_q <= '0; jdur_q <= '0; jvalid_q <= 1'b0; jind_q <= '0;
      i_q <= '0; diag_q <= '0; left_q <= '0;
      as_q <= '0; adur_q <= '0; as_ok_q <= 1'b0;
      aind_q <= '0; subc_q <= '0; da_q <= '0; dj_q <= '0; up_q <= '0;
      out_valid_q <= 1'b0;
      dist_q <= '0; osat_q <= 1'b0; olong_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) weight_q <= cfg_data_i;
      if (state_q == S_DONE && last_q) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            unique case (func_e'(func_i))
              FUNC_SUB, FUNC_INDEL: ;
              FUNC_A: begin
                if (a_new) begin
                  b_cnt_q <= '0; sat_q <= 1'b0; long_q <= 1'b0;
                end
                if (32'(a_len_eff) < MAX_LEN) a_len_q <= a_len_eff + LenW'(1);
                else long_q <= 1'b1;
                a_closed_q <= last_i;
              end
              FUNC_B: begin
                a_closed_q <= 1'b1;
                js_q <= row_state_i; jdur_q <= duration_i;
                jvalid_q <= rs_ok;
                last_q <= last_i;
                if (32'(b_cnt_q) < MAX_LEN) begin
                  first_q <= (b_cnt_q == '0);
                  state_q <= S_JIND;
                end else begin
                  long_q <= 1'b1;
                  state_q <= S_DONE;
                end
              end
            endcase
          end
        end
        S_JIND: begin
          // indel of B state was read at the accepting edge
          jind_q <= jvalid_q ? ind_rdata : CostW'(0);
          dj_q <= weight_q * jdur_q;
          i_q <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          // row i and A element i-1 being read
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          as_q <= as_w; adur_q <= adur_w; as_ok_q <= as_ok;
          up_q <= row_rdata;
          state_q <= S_MUL;
        end
        S_MUL: begin
          aind_q <= ind_rdata; subc_q <= sub_rdata;
          da_q <= weight_q * adur_q;
          state_q <= S_CALC;
        end
        S_CALC: begin
          if (cell_ovf) sat_q <= 1'b1;
          diag_q <= up_q;
          left_q <= cell_w;
          if (i_q == a_len_q) begin
            i_q <= '0;
            if (first_q) begin
              first_q <= 1'b0;
              state_q <= S_RD;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            i_q <= i_q + RowW'(1);
            state_q <= S_RD;
          end
        end
        S_DONE: begin
          if (last_q) begin
            // left_q holds row_costs[a_len] of the latest column
            dist_q <= left_q;
            osat_q <= sat_q; olong_q <= long_q;
            a_len_q <= '0; b_cnt_q <= '0; sat_q <= 1'b0; long_q <= 1'b0;
            a_closed_q <= 1'b0;
          end else if (32'(b_cnt_q) < MAX_LEN) begin
            b_cnt_q <= b_cnt_q + LenW'(1);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign saturated_o = osat_q;
  assign too_long_o  = olong_q;

endmodule

// ----- design/sded_checker.sv -----
// ----------------------------------------------------------------------------
// sded_checker: port-level checks for the edit distance core
// Handshake and flow checks, bound to the top level.
// ----------------------------------------------------------------------------
module sded_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic cfg_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [31:0] distance_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o))
    else $error("result dropped while stalled");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken with stalled result");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> cfg_ready_o)
    else $error("cfg blocked while idle");

endmodule

bind spell_duration_edit_distance_core sded_checker u_sded_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cfg_ready_o,
  .out_valid_o, .out_ready_i, .distance_o);
